>>> rtl/s2x_pkg.sv
// Package for the sRGB to XYZ (D50) converter: widths, matrix coefficients
// and the function that builds the sRGB linearization table entries. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package s2x_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CODE_W    = 8;
    localparam int LIN_W     = 16;
    localparam int OUT_W     = 17;
    localparam int COEF_W    = FRAC_BITS;
    localparam int PROD_W    = LIN_W + COEF_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int RND_W     = ACC_W + 1;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;
    localparam logic [OUT_W-1:0] ONE_Q16 = OUT_W'(65536);

    typedef logic [COEF_W-1:0] coef_t;
    typedef logic [LIN_W-1:0]  lin_t;
    typedef logic [PROD_W-1:0] prod_t;

    // Coefficients given in units of 1e-7, rounded half-up to FRAC_BITS.
    function automatic coef_t coef_of(longint unsigned e7);
        longint unsigned q;
        q = ((e7 << FRAC_BITS) + 64'd5000000) / 64'd10000000;
        return coef_t'(q);
    endfunction

    localparam coef_t MAT [9] = '{
        coef_of(64'd4360747), coef_of(64'd3850649), coef_of(64'd1430804),
        coef_of(64'd2225045), coef_of(64'd7168786), coef_of(64'd606169),
        coef_of(64'd139322),  coef_of(64'd971045),  coef_of(64'd7141733)
    };

    // One entry of the linearization table, evaluated at elaboration.
    function automatic lin_t lin_entry(int c);
        real    s;
        real    v;
        longint r;
        if (100000 * c < 1031475) begin
            r = (64'd6553600 * c + 64'd164730) / 64'd329460;
        end else begin
            s = (real'(c) / 255.0 + 0.055) / 1.055;
            v = (s ** 2.4) * 65536.0 + 0.5;
            r = longint'($floor(v));
        end
        if (r > 65535) begin
            r = 65535;
        end
        return lin_t'(r);
    endfunction

endpackage
`default_nettype wire

>>> rtl/srgb_to_xyz_d50_unit.sv
// Usage:
// Converts one 8-bit sRGB pixel per transaction to CIE XYZ adapted to D50.
// Input stream s_axis: tdata carries red [7:0], green [15:8], blue [23:16].
// Output stream m_axis: tdata carries X [16:0], Y [33:17], Z [50:34],
// upper bits zero; 65536 stands for 1.0.
// There are four register stages: input register, table lookup, nine
// multipliers, then sum with rounding and saturation. The result shows on
// m_tvalid when the accepted transaction reaches the last of the four registers.
// Throughput is one pixel per cycle while m_tready does not stall the output.
// The four stages advance together whenever the output register is empty
// or being taken, so s_tready follows m_tready while the output is full.
// A stall holds every stage in place: nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits; the table is
// constant logic and needs no initialization.
// Depends on s2x_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srgb_to_xyz_d50_unit
    import s2x_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // red, green, blue
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata    // x, y, z, zero pad
);

    logic                    adv;
    logic [3:0]              vld_reg, vld_next;
    logic [CODE_W-1:0]       code_reg [3];
    lin_t                    lin_reg  [3];
    prod_t                   prod_reg [9];
    logic [OUT_W-1:0]        xyz_reg  [3];
    logic [OUT_W-1:0]        xyz_next [3];
    lin_t                    lin_rom  [256];

    for (genvar i = 0; i < 256; i++) begin : g_rom
        localparam lin_t ENTRY = lin_entry(i);
        assign lin_rom[i] = ENTRY;
    end

    assign adv      = !vld_reg[3] || m_tready;
    assign s_tready = adv;
    assign vld_next = {vld_reg[2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    always_comb begin
        logic [RND_W-1:0] sum;
        logic [RND_W-1:0] rnd;
        for (int r = 0; r < 3; r++) begin
            sum = RND_W'(prod_reg[3*r]) + RND_W'(prod_reg[3*r+1])
                + RND_W'(prod_reg[3*r+2]) + (RND_W'(1) << (FRAC_BITS - 1));
            rnd = sum >> FRAC_BITS;
            xyz_next[r] = (rnd > RND_W'(ONE_Q16)) ? ONE_Q16 : OUT_W'(rnd);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                code_reg[c] <= s_tdata[c*CODE_W +: CODE_W];
                lin_reg[c]  <= lin_rom[code_reg[c]];
            end
            for (int k = 0; k < 9; k++) begin
                prod_reg[k] <= PROD_W'(lin_reg[k%3]) * PROD_W'(MAT[k]);
            end
            for (int r = 0; r < 3; r++) begin
                xyz_reg[r] <= xyz_next[r];
            end
        end
    end

    assign m_tvalid = vld_reg[3];
    assign m_tdata  = {(OUT_DATA_W - 3*OUT_W)'(0), xyz_reg[2], xyz_reg[1], xyz_reg[0]};

endmodule
`default_nettype wire

>>> rtl/s2x_checker.sv
// Port-level checker for srgb_to_xyz_d50_unit, bound into every instance of it.
// Depends on s2x_pkg.
`timescale 1ns / 1ps
`default_nettype none
module s2x_checker
    import s2x_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [IN_DATA_W-1:0]  s_tdata,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata
);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[16:0] <= ONE_Q16 && m_tdata[33:17] <= ONE_Q16
                  && m_tdata[50:34] <= ONE_Q16 && m_tdata[55:51] == '0)
        else $error("result out of range");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input blocked with free output");

endmodule

bind srgb_to_xyz_d50_unit s2x_checker u_s2x_checker (.*);
`default_nettype wire
